// File: rtl/lnat_pkg.sv
// Shared types and constants for the learned node address table.
// No dependencies; used by rtl/learned_node_address_table.sv.
package lnat_pkg;

  localparam int unsigned NODE_SLOTS_DEF = 32;
  localparam int unsigned ADDR_W         = 48;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned SLOT_W         = 5;
  localparam int unsigned AGE_W          = 23;
  localparam int unsigned MS_PER_SEC     = 1000;

  // Divide by 1000 as multiply and shift: ceil(2^38 / 1000) with a 6-bit margin
  // past the 32-bit dividend gives the exact floor for every 32-bit value.
  localparam int unsigned RECIP_W     = 29;
  localparam int unsigned RECIP_SHIFT = TIME_W + 6;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 29'd274877907;

  typedef enum logic {
    OP_OBSERVE = 1'b0,
    OP_READ    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_REFRESH = 2'd0,
    STAT_INSERT  = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_READ    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_DIVIDE,
    ST_DONE
  } state_e;

endpackage

// File: rtl/learned_node_address_table.sv
// Learned node address table. Observe: one compare per cycle over the live slots, up to
// a hit or the last live slot. Read: memory read, then age = elapsed ms / 1000 by one
// reciprocal multiply, skipped for an empty slot. Next request once result queued.
// Reset (async, active low) empties the table through the fill count; memories not cleared.
// Depends on rtl/lnat_pkg.sv.
module learned_node_address_table #(
  parameter int unsigned NODE_SLOTS = lnat_pkg::NODE_SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [lnat_pkg::ADDR_W-1:0] sender_address_i,
  input  logic [lnat_pkg::SLOT_W-1:0] read_slot_i,
  input  logic [lnat_pkg::TIME_W-1:0] time_ms_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [lnat_pkg::SLOT_W-1:0] slot_index_o,
  output logic                        entry_valid_o,
  output logic [lnat_pkg::ADDR_W-1:0] entry_address_o,
  output logic [lnat_pkg::AGE_W-1:0]  age_seconds_o
);

  // Slot index width, and a counter width that can hold NODE_SLOTS itself.
  localparam int unsigned IDX_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(NODE_SLOTS + 1);
  // Width used when comparing a 5-bit read slot against the fill count.
  localparam int unsigned SCW   = (CNT_W > lnat_pkg::SLOT_W) ? CNT_W : lnat_pkg::SLOT_W;
  localparam int unsigned PROD_W = lnat_pkg::TIME_W + lnat_pkg::RECIP_W;

  // Entries are never removed and always land in the lowest free slot, so the
  // valid slots are exactly 0 .. count_q-1. The fill count replaces valid bits.
  logic [lnat_pkg::ADDR_W-1:0] addr_mem [NODE_SLOTS];
  logic [lnat_pkg::TIME_W-1:0] seen_mem [NODE_SLOTS];

  lnat_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            scan_q, scan_d;     // next slot to read during scan
  logic                        cmp_vld_q, cmp_vld_d; // read data in flight is a live slot
  logic [IDX_W-1:0]            cmp_idx_q, cmp_idx_d;

  logic [lnat_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [lnat_pkg::TIME_W-1:0] time_q, time_d;
  logic [lnat_pkg::SLOT_W-1:0] rslot_q, rslot_d;

  // Pending result, built while the request is worked on.
  lnat_pkg::status_e           pend_status_q, pend_status_d;
  logic [lnat_pkg::SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic                        pend_valid_q, pend_valid_d;
  logic [lnat_pkg::ADDR_W-1:0] pend_addr_q, pend_addr_d;

  // dq_q holds the elapsed milliseconds, then the age in seconds.
  logic [lnat_pkg::TIME_W-1:0] dq_q, dq_d;

  // Output register.
  logic                        out_valid_q, out_valid_d;
  lnat_pkg::status_e           out_status_q, out_status_d;
  logic [lnat_pkg::SLOT_W-1:0] out_slot_q, out_slot_d;
  logic                        out_evalid_q, out_evalid_d;
  logic [lnat_pkg::ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [lnat_pkg::AGE_W-1:0]  out_age_q, out_age_d;

  // Memory port controls and registered read data.
  logic [IDX_W-1:0]            rd_idx;
  logic [IDX_W-1:0]            wr_idx;
  logic                        we_addr;
  logic                        we_seen;
  logic [lnat_pkg::ADDR_W-1:0] addr_rdata_q;
  logic [lnat_pkg::TIME_W-1:0] seen_rdata_q;

  logic                        in_accept;
  logic                        hit;
  logic                        scan_end;
  logic                        table_full;
  logic                        slot_live;
  logic                        out_free;
  logic [PROD_W-1:0]           recip_prod;

  assign in_stall_o = (state_q != lnat_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Compare of the slot read last cycle against the searched address.
  assign hit        = cmp_vld_q && (addr_rdata_q == addr_q);
  // Every live slot issued and compared without a hit.
  assign scan_end   = !cmp_vld_q && (scan_q == count_q);
  assign table_full = (count_q == CNT_W'(NODE_SLOTS));
  assign slot_live  = (SCW'(rslot_q) < SCW'(count_q));
  assign out_free   = !out_valid_q || !out_stall_i;

  // Seconds = (elapsed * RECIP_MUL) >> RECIP_SHIFT.
  assign recip_prod = PROD_W'(dq_q) * PROD_W'(lnat_pkg::RECIP_MUL);

  assign rd_idx = (state_q == lnat_pkg::ST_SCAN) ? scan_q[IDX_W-1:0] : IDX_W'(rslot_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      lnat_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = (op_i == lnat_pkg::OP_READ) ? lnat_pkg::ST_RD_ISSUE : lnat_pkg::ST_SCAN;
        end
      end
      lnat_pkg::ST_SCAN: begin
        if (hit || scan_end) begin
          state_d = lnat_pkg::ST_DONE;
        end
      end
      lnat_pkg::ST_RD_ISSUE: state_d = lnat_pkg::ST_RD_WAIT;
      lnat_pkg::ST_RD_WAIT: begin
        state_d = slot_live ? lnat_pkg::ST_DIVIDE : lnat_pkg::ST_DONE;
      end
      lnat_pkg::ST_DIVIDE: state_d = lnat_pkg::ST_DONE;
      lnat_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = lnat_pkg::ST_IDLE;
        end
      end
      default: state_d = lnat_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    count_d       = count_q;
    scan_d        = scan_q;
    cmp_vld_d     = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    addr_d        = addr_q;
    time_d        = time_q;
    rslot_d       = rslot_q;
    pend_status_d = pend_status_q;
    pend_slot_d   = pend_slot_q;
    pend_valid_d  = pend_valid_q;
    pend_addr_d   = pend_addr_q;
    dq_d          = dq_q;
    wr_idx        = cmp_idx_q;
    we_addr       = 1'b0;
    we_seen       = 1'b0;
    out_valid_d   = out_valid_q && out_stall_i;
    out_status_d  = out_status_q;
    out_slot_d    = out_slot_q;
    out_evalid_d  = out_evalid_q;
    out_addr_d    = out_addr_q;
    out_age_d     = out_age_q;

    case (state_q)
      lnat_pkg::ST_IDLE: begin
        if (in_accept) begin
          addr_d  = sender_address_i;
          time_d  = time_ms_i;
          rslot_d = read_slot_i;
          scan_d  = '0;
        end
      end

      lnat_pkg::ST_SCAN: begin
        // Issue one read a cycle while live slots remain.
        if (scan_q != count_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[IDX_W-1:0];
          scan_d    = scan_q + CNT_W'(1);
        end
        pend_valid_d = 1'b0;
        pend_addr_d  = '0;
        dq_d         = '0;
        if (hit) begin
          we_seen       = 1'b1;
          wr_idx        = cmp_idx_q;
          pend_status_d = lnat_pkg::STAT_REFRESH;
          pend_slot_d   = lnat_pkg::SLOT_W'(cmp_idx_q);
        end else if (scan_end) begin
          if (table_full) begin
            pend_status_d = lnat_pkg::STAT_FULL;
            pend_slot_d   = '0;
          end else begin
            we_addr       = 1'b1;
            we_seen       = 1'b1;
            wr_idx        = count_q[IDX_W-1:0];
            count_d       = count_q + CNT_W'(1);
            pend_status_d = lnat_pkg::STAT_INSERT;
            pend_slot_d   = lnat_pkg::SLOT_W'(count_q);
          end
        end
      end

      lnat_pkg::ST_RD_WAIT: begin
        pend_status_d = lnat_pkg::STAT_READ;
        pend_slot_d   = rslot_q;
        if (slot_live) begin
          pend_valid_d = 1'b1;
          pend_addr_d  = addr_rdata_q;
          dq_d         = time_q - seen_rdata_q;  // wraps modulo 2^32
        end else begin
          pend_valid_d = 1'b0;
          pend_addr_d  = '0;
          dq_d         = '0;
        end
      end

      lnat_pkg::ST_DIVIDE: begin
        dq_d = lnat_pkg::TIME_W'(recip_prod[lnat_pkg::RECIP_SHIFT +: lnat_pkg::AGE_W]);
      end

      lnat_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = pend_status_q;
          out_slot_d   = pend_slot_q;
          out_evalid_d = pend_valid_q;
          out_addr_d   = pend_addr_q;
          out_age_d    = dq_q[lnat_pkg::AGE_W-1:0];
        end
      end

      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lnat_pkg::ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmp_idx_q     <= cmp_idx_d;
    addr_q        <= addr_d;
    time_q        <= time_d;
    rslot_q       <= rslot_d;
    pend_status_q <= pend_status_d;
    pend_slot_q   <= pend_slot_d;
    pend_valid_q  <= pend_valid_d;
    pend_addr_q   <= pend_addr_d;
    dq_q          <= dq_d;
    out_status_q  <= out_status_d;
    out_slot_q    <= out_slot_d;
    out_evalid_q  <= out_evalid_d;
    out_addr_q    <= out_addr_d;
    out_age_q     <= out_age_d;
  end

  // Address and last-seen memories: one write, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_addr) begin
      addr_mem[wr_idx] <= addr_q;
    end
    if (we_seen) begin
      seen_mem[wr_idx] <= time_q;
    end
    addr_rdata_q <= addr_mem[rd_idx];
    seen_rdata_q <= seen_mem[rd_idx];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_index_o    = out_slot_q;
  assign entry_valid_o   = out_evalid_q;
  assign entry_address_o = out_addr_q;
  assign age_seconds_o   = out_age_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(NODE_SLOTS))
    else $error("fill count beyond table size");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lnat_pkg::ST_SCAN && !hit && scan_end && !table_full)
    |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not advance fill count");

  a_full_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == lnat_pkg::STAT_FULL)
    |-> (slot_index_o == '0 && !entry_valid_o))
    else $error("table full result carries slot data");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("request taken while previous one still in work");
`endif

endmodule
